### rtl/loc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the length operand codec.
package loc_pkg;

  localparam int unsigned VALUE_W  = 30;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TDATA_W  = 40;
  localparam int unsigned OUT_TUSER_W = 2;

  // Input kind codes carried on in_tuser.
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // Upper bounds of the one-, two- and three-byte encodings.
  localparam logic [VALUE_W-1:0] MAX_ONE_BYTE   = 30'h0000003F;
  localparam logic [VALUE_W-1:0] MAX_TWO_BYTE   = 30'h00003FFF;
  localparam logic [VALUE_W-1:0] MAX_THREE_BYTE = 30'h003FFFFF;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_ENC
  } loc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input word is taken this cycle
    logic emit;    // the next trailing encoded byte is produced this cycle
  } loc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the output register can take a word this cycle
    logic enc_more;  // the offered encode item needs trailing bytes
    logic enc_last;  // the trailing byte about to go out is the final one
  } loc_stat_t;

endpackage

### rtl/loc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the length operand codec.
module loc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  loc_pkg::loc_stat_t stat,
  output logic               in_tready,
  output loc_pkg::loc_cmd_t  cmd
);
  import loc_pkg::*;

  loc_state_t state_r;
  loc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && stat.out_free && stat.enc_more) begin
          state_nxt = ST_ENC;
        end
      end
      ST_ENC: begin
        if (stat.out_free && stat.enc_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.emit   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = stat.out_free;
        cmd.accept = in_tvalid && stat.out_free;
      end
      ST_ENC: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/loc_dp.sv
`timescale 1ns / 1ps
// Datapath of the length operand codec: encoder, decoder state and output register.
module loc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  loc_pkg::loc_cmd_t             cmd,
  output loc_pkg::loc_stat_t            stat,
  input  logic                          in_kind,
  input  logic [loc_pkg::VALUE_W-1:0]   in_value,
  input  logic [loc_pkg::BYTE_W-1:0]    in_byte,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [loc_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_byte_ready,
  output logic                          out_last,
  output logic [loc_pkg::VALUE_W-1:0]   out_value,
  output logic                          out_value_ready
);
  import loc_pkg::*;

  // Encoder hold registers.
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [1:0]         idx_r, idx_nxt;

  // Decoder state.
  logic [1:0]         pend_r, pend_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;

  // Output register.
  logic               ovld_r, ovld_nxt;
  logic [BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic               obrdy_r, obrdy_nxt;
  logic               olast_r, olast_nxt;
  logic [VALUE_W-1:0] oval_r, oval_nxt;
  logic               ovrdy_r, ovrdy_nxt;

  logic [1:0]         follow;
  logic [5:0]         head_bits;
  logic [BYTE_W-1:0]  trail_byte;
  logic [VALUE_W-1:0] acc_shift;

  always_comb begin
    if (in_value > MAX_THREE_BYTE) begin
      follow = 2'd3;
    end else if (in_value > MAX_TWO_BYTE) begin
      follow = 2'd2;
    end else if (in_value > MAX_ONE_BYTE) begin
      follow = 2'd1;
    end else begin
      follow = 2'd0;
    end
  end

  always_comb begin
    case (follow)
      2'd1:    head_bits = in_value[13:8];
      2'd2:    head_bits = in_value[21:16];
      2'd3:    head_bits = in_value[29:24];
      default: head_bits = in_value[5:0];
    endcase
  end

  always_comb begin
    case (idx_r)
      2'd2:    trail_byte = val_r[15:8];
      2'd3:    trail_byte = val_r[23:16];
      default: trail_byte = val_r[7:0];
    endcase
  end

  assign acc_shift = {acc_r[VALUE_W-BYTE_W-1:0], in_byte};

  assign stat.out_free = !ovld_r || out_tready;
  assign stat.enc_more = (in_kind == KIND_ENCODE) && (follow != 2'd0);
  assign stat.enc_last = (idx_r == 2'd1);

  always_comb begin
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    ovld_nxt  = ovld_r && !out_tready;
    obyte_nxt = obyte_r;
    obrdy_nxt = obrdy_r;
    olast_nxt = olast_r;
    oval_nxt  = oval_r;
    ovrdy_nxt = ovrdy_r;

    if (cmd.emit) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = trail_byte;
      obrdy_nxt = 1'b1;
      olast_nxt = (idx_r == 2'd1);
      oval_nxt  = '0;
      ovrdy_nxt = 1'b0;
      idx_nxt   = idx_r - 2'd1;
    end else if (cmd.accept) begin
      if (in_kind == KIND_ENCODE) begin
        // The first byte always goes out at once; trailing bytes follow.
        ovld_nxt  = 1'b1;
        obyte_nxt = {follow, head_bits};
        obrdy_nxt = 1'b1;
        olast_nxt = (follow == 2'd0);
        oval_nxt  = '0;
        ovrdy_nxt = 1'b0;
        val_nxt   = in_value;
        idx_nxt   = follow;
      end else if (pend_r == 2'd0) begin
        if (in_byte[7:6] == 2'd0) begin
          ovld_nxt  = 1'b1;
          obyte_nxt = '0;
          obrdy_nxt = 1'b0;
          olast_nxt = 1'b0;
          oval_nxt  = {{(VALUE_W-6){1'b0}}, in_byte[5:0]};
          ovrdy_nxt = 1'b1;
        end else begin
          acc_nxt  = {{(VALUE_W-6){1'b0}}, in_byte[5:0]};
          pend_nxt = in_byte[7:6];
        end
      end else begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          ovld_nxt  = 1'b1;
          obyte_nxt = '0;
          obrdy_nxt = 1'b0;
          olast_nxt = 1'b0;
          oval_nxt  = acc_shift;
          ovrdy_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
      pend_r <= 2'd0;
      acc_r  <= '0;
      idx_r  <= 2'd0;
    end else begin
      ovld_r <= ovld_nxt;
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    obyte_r <= obyte_nxt;
    obrdy_r <= obrdy_nxt;
    olast_r <= olast_nxt;
    oval_r  <= oval_nxt;
    ovrdy_r <= ovrdy_nxt;
  end

  assign out_tvalid      = ovld_r;
  assign out_byte        = obyte_r;
  assign out_byte_ready  = obrdy_r;
  assign out_last        = olast_r;
  assign out_value       = oval_r;
  assign out_value_ready = ovrdy_r;

endmodule

### rtl/length_operand_codec_unit.sv
`timescale 1ns / 1ps
// The first result word of an item appears in the cycle after the input word is taken.
// A decode word gives at most one result word; an encode word gives 1 to 4 encoded
// bytes, which leave the single output register in turn as out_tready allows.
// The input is not ready while trailing encoded bytes are still being produced.
// Reset (synchronous, active low) empties the output register and clears the decoder state.
module length_operand_codec_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [loc_pkg::TDATA_W-1:0]      in_tdata,   // value_in [29:0], byte_in [37:30]
  input  logic                             in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [loc_pkg::TDATA_W-1:0]      out_tdata,  // out_byte [7:0], value_out [37:8]
  output logic [loc_pkg::OUT_TUSER_W-1:0]  out_tuser,  // byte_ready [0], value_ready [1]
  output logic                             out_tlast
);
  import loc_pkg::*;

  loc_cmd_t           cmd;
  loc_stat_t          stat;
  logic [BYTE_W-1:0]  obyte;
  logic [VALUE_W-1:0] oval;
  logic               obrdy;
  logic               ovrdy;

  loc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  loc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_tuser),
    .in_value        (in_tdata[VALUE_W-1:0]),
    .in_byte         (in_tdata[VALUE_W+BYTE_W-1:VALUE_W]),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_byte        (obyte),
    .out_byte_ready  (obrdy),
    .out_last        (out_tlast),
    .out_value       (oval),
    .out_value_ready (ovrdy)
  );

  assign out_tdata = {{(TDATA_W-VALUE_W-BYTE_W){1'b0}}, oval, obyte};
  assign out_tuser = {ovrdy, obrdy};

endmodule

### tb/length_operand_codec_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the encoded bytes and decoded values of the codec and compares them.
module length_operand_codec_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [loc_pkg::TDATA_W-1:0]      in_tdata,   // value_in [29:0], byte_in [37:30]
  input  logic                             in_tuser,   // kind
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [loc_pkg::TDATA_W-1:0]      out_tdata,  // out_byte [7:0], value_out [37:8]
  input  logic [loc_pkg::OUT_TUSER_W-1:0]  out_tuser,  // byte_ready [0], value_ready [1]
  input  logic                             out_tlast,
  output int                               mismatch_count,
  output int                               words_awaited
);
  import loc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]  code_byte;
    logic               byte_rdy;
    logic               last;
    logic [VALUE_W-1:0] value;
    logic               value_rdy;
  } codec_word_t;

  codec_word_t        expected_words[$];
  logic [1:0]         dec_pending;
  logic [VALUE_W-1:0] dec_acc;

  initial begin
    mismatch_count = 0;
    words_awaited  = 0;
    dec_pending    = '0;
    dec_acc        = '0;
  end

  function automatic codec_word_t make_word(logic [BYTE_W-1:0] b, logic br, logic lst,
                                            logic [VALUE_W-1:0] v, logic vr);
    codec_word_t w;
    w.code_byte = b;
    w.byte_rdy  = br;
    w.last      = lst;
    w.value     = v;
    w.value_rdy = vr;
    return w;
  endfunction

  // Works out the words that one accepted input word gives rise to, in order.
  task automatic predict_codec_words(logic kind, logic [VALUE_W-1:0] val, logic [BYTE_W-1:0] b);
    int unsigned follow;
    logic [VALUE_W-1:0] shifted;
    if (kind == KIND_ENCODE) begin
      if (val <= MAX_ONE_BYTE) begin
        expected_words.push_back(make_word(val[BYTE_W-1:0], 1'b1, 1'b1, '0, 1'b0));
      end else begin
        follow = 1;
        if (val > MAX_TWO_BYTE) follow = 2;
        if (val > MAX_THREE_BYTE) follow = 3;
        shifted = val >> (8 * follow);
        expected_words.push_back(make_word({follow[1:0], shifted[5:0]}, 1'b1, 1'b0, '0, 1'b0));
        for (int i = follow; i > 0; i--) begin
          shifted = val >> (8 * (i - 1));
          expected_words.push_back(make_word(shifted[BYTE_W-1:0], 1'b1, (i == 1), '0, 1'b0));
        end
      end
    end else if (dec_pending == 2'd0) begin
      // A leading byte with a zero count carries the whole value in its low six bits.
      if (b[7:6] == 2'd0) begin
        expected_words.push_back(make_word('0, 1'b0, 1'b0, {24'd0, b[5:0]}, 1'b1));
      end else begin
        dec_acc     = {24'd0, b[5:0]};
        dec_pending = b[7:6];
      end
    end else begin
      dec_acc     = {dec_acc[VALUE_W-9:0], b};
      dec_pending = dec_pending - 2'd1;
      if (dec_pending == 2'd0) begin
        expected_words.push_back(make_word('0, 1'b0, 1'b0, dec_acc, 1'b1));
      end
    end
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    codec_word_t exp_w;
    if (!rst_n) begin
      expected_words.delete();
      dec_pending = '0;
      dec_acc     = '0;
    end else begin
      // An output word at this edge always belongs to an earlier input word.
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual tdata 0x%0h tuser 0x%0h last %0b",
                   $time, out_tdata, out_tuser, out_tlast);
          mismatch_count++;
        end else begin
          exp_w = expected_words.pop_front();
          compare_field("out_byte", exp_w.code_byte, out_tdata[7:0]);
          compare_field("byte_ready", exp_w.byte_rdy, out_tuser[0]);
          compare_field("last", exp_w.last, out_tlast);
          compare_field("value_out", exp_w.value, out_tdata[37:8]);
          compare_field("value_ready", exp_w.value_rdy, out_tuser[1]);
        end
      end
      if (in_tvalid && in_tready) begin
        predict_codec_words(in_tuser, in_tdata[29:0], in_tdata[37:30]);
      end
    end
    words_awaited = expected_words.size();
  end

endmodule

### tb/tb_length_operand_codec_unit.sv
`timescale 1ns / 1ps
// Testbench top for the length operand codec: stimulus, back-pressure and the verdict.
module tb_length_operand_codec_unit;
  import loc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 160;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [TDATA_W-1:0]         in_tdata;   // value_in [29:0], byte_in [37:30]
  logic                       in_tuser;   // kind
  logic                       out_tvalid;
  logic                       out_tready;
  logic [TDATA_W-1:0]         out_tdata;  // out_byte [7:0], value_out [37:8]
  logic [OUT_TUSER_W-1:0]     out_tuser;  // byte_ready [0], value_ready [1]
  logic                       out_tlast;

  int  mismatch_count;
  int  words_awaited;
  int  cycle_count;
  int  items_sent;
  bit  in_burst;
  bit  out_burst;
  int  stall_left;

  length_operand_codec_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  length_operand_codec_checker checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .words_awaited  (words_awaited)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side back-pressure; bursts switch the stalls off for a while.
  initial begin
    out_tready = 1'b0;
    out_burst  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 59) == 0) out_burst = !out_burst;
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!out_burst && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word was taken.
  task automatic send_word(logic kind, logic [VALUE_W-1:0] val, logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, b, val};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // The unused field of each word carries random junk.
  task automatic encode_value(logic [VALUE_W-1:0] val);
    send_word(KIND_ENCODE, val, BYTE_W'($urandom()));
  endtask

  task automatic decode_byte(logic [BYTE_W-1:0] b);
    send_word(KIND_DECODE, VALUE_W'($urandom()), b);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 4))
      0:       return VALUE_W'($urandom_range(0, 63));
      1:       return VALUE_W'($urandom_range(64, 32'h3FFF));
      2:       return VALUE_W'($urandom_range(32'h4000, 32'h3FFFFF));
      3:       return VALUE_W'($urandom_range(32'h400000, 32'h3FFFFFFF));
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [1:0] cnt;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_ENCODE;
    items_sent = 0;
    in_burst   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Boundaries of every encoding length.
    encode_value(30'd0);
    encode_value(30'd63);
    encode_value(30'd64);
    encode_value(30'h3FFF);
    encode_value(30'h4000);
    encode_value(30'h3FFFFF);
    encode_value(30'h400000);
    encode_value(30'h3FFFFFFF);
    // Single-byte decodes, then the largest two-, three- and four-byte words.
    decode_byte(8'h00);
    decode_byte(8'h3F);
    decode_byte(8'h7F);
    decode_byte(8'hFF);
    decode_byte(8'hBF);
    decode_byte(8'hFF);
    decode_byte(8'hFF);
    decode_byte(8'hFF);
    decode_byte(8'hFF);
    decode_byte(8'hFF);
    decode_byte(8'hFF);
    // A non-minimal encoding of a small value.
    decode_byte(8'h40);
    decode_byte(8'h05);
    // An encode slipped into a decode in progress must leave it undisturbed.
    decode_byte(8'h80);
    decode_byte(8'h12);
    encode_value(30'd100);
    decode_byte(8'h34);

    while (items_sent < 25 + RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: encode_value(random_value());
        17, 18, 19: decode_byte(BYTE_W'($urandom()));
        default: begin
          // Well-formed operand with random content, occasionally split by an encode.
          cnt = 2'($urandom_range(0, 3));
          decode_byte({cnt, 6'($urandom())});
          for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 6) == 0) encode_value(random_value());
            decode_byte(BYTE_W'($urandom()));
          end
        end
      endcase
    end
    in_tvalid <= 1'b0;

    while (words_awaited != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### length_operand_codec_unit.f
rtl/loc_pkg.sv
rtl/loc_ctrl.sv
rtl/loc_dp.sv
rtl/length_operand_codec_unit.sv
tb/length_operand_codec_checker.sv
tb/tb_length_operand_codec_unit.sv
